### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the TLV CRC-32 deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TLV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TLV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/tlvcrc_pkg.sv
// ----------------------------------------------------------------------------
// tlvcrc_pkg
// Types, codes and the CRC-32 byte update shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvcrc_pkg;

    // Reflected CRC-32: polynomial, preset and final XOR.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Position of the last byte in a 4-byte length or CRC field.
    localparam logic [1:0] FIELD_LAST_IDX = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  frame_type;
        logic [31:0] frame_length;
    } result_t;

    // One byte of the reflected CRC-32; unrolls into an XOR network.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/tlvcrc_if.sv
// ----------------------------------------------------------------------------
// tlvcrc_if
// Valid/ready channels for the raw byte stream and the deframed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlvcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tlvcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic [31:0] frame_length;

    modport source (output valid, output out_kind, output out_byte, output frame_type,
                    output frame_length, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input frame_type,
                    input frame_length, output ready);
endinterface

`default_nettype wire

### rtl/tlvcrc_parser.sv
// ----------------------------------------------------------------------------
// tlvcrc_parser
// Frame state machine and CRC accumulation, one byte per accepted request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlvcrc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_ready,
    output logic                res_valid,
    output tlvcrc_pkg::result_t res
);
    import tlvcrc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] remain_reg, remain_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;

    logic        accept;
    logic [31:0] length_shift;
    logic [31:0] rx_crc_shift;

    assign accept       = in_valid & in_ready;
    assign length_shift = {length_reg[23:0], in_byte};
    assign rx_crc_shift = {rx_crc_reg[23:0], in_byte};

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE:    phase_next = PH_LENGTH;
                PH_LENGTH:
                begin
                    if (idx_reg == FIELD_LAST_IDX)
                    begin
                        phase_next = (length_shift == 32'd0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remain_reg == 32'd1)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    if (idx_reg == FIELD_LAST_IDX)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                default:    phase_next = PH_TYPE;
            endcase
        end
    end

    // Datapath updates and the result of the current byte.
    always_comb
    begin
        idx_next     = idx_reg;
        remain_next  = remain_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        crc_next     = crc_reg;
        rx_crc_next  = rx_crc_reg;
        res_valid    = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.data         = 8'd0;
        res.frame_type   = type_reg;
        res.frame_length = length_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next   = in_byte;
                    length_next = 32'd0;
                    idx_next    = 2'd0;
                    rx_crc_next = 32'd0;
                    crc_next    = CRC_INIT;
                end
                PH_LENGTH:
                begin
                    length_next = length_shift;
                    idx_next    = idx_reg + 2'd1;
                    if (idx_reg == FIELD_LAST_IDX)
                    begin
                        remain_next = length_shift;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next    = crc32_byte(crc_reg, in_byte);
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1)
                    begin
                        idx_next = 2'd0;
                    end
                    res_valid = 1'b1;
                    res.data  = in_byte;
                end
                PH_CRC:
                begin
                    rx_crc_next = rx_crc_shift;
                    idx_next    = idx_reg + 2'd1;
                    if (idx_reg == FIELD_LAST_IDX)
                    begin
                        res_valid = 1'b1;
                        res.kind  = ((crc_reg ^ CRC_INIT) == rx_crc_shift) ? KIND_GOOD
                                                                           : KIND_BAD;
                        idx_next  = 2'd0;
                        crc_next  = CRC_INIT;
                    end
                end
                default:
                begin
                    idx_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            idx_reg    <= 2'd0;
            remain_reg <= 32'd0;
            type_reg   <= 8'd0;
            length_reg <= 32'd0;
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

    // The payload phase is only entered with a nonzero count and a cleared index.
    `TLV_ASSERT_IMP(a_payload_count_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD, remain_reg != 32'd0)
    `TLV_ASSERT_IMP(a_payload_index_clear, clk, rst_n, phase_reg == PH_PAYLOAD, idx_reg == 2'd0)
    `TLV_ASSERT_NXT(a_verdict_restarts, clk, rst_n, res_valid && res.kind != KIND_PAYLOAD, phase_reg == PH_TYPE)

endmodule

`default_nettype wire

### rtl/tlvcrc_out_buf.sv
// ----------------------------------------------------------------------------
// tlvcrc_out_buf
// Output register with a skid entry, so the input can still take one more result under a stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlvcrc_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlvcrc_pkg::result_t push_data,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output tlvcrc_pkg::result_t out_data
);
    import tlvcrc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    out_fire;

    assign out_fire  = out_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                main_next      = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry only ever backs up a full output register.
    `TLV_ASSERT_IMP(a_skid_behind_main, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A result arrives only while the skid entry is free.
    `TLV_ASSERT_IMP(a_push_has_space, clk, rst_n, push, !skid_valid_reg)
    // A result pushed into a stalled register lands in the skid entry.
    `TLV_ASSERT_NXT(a_stall_fills_skid, clk, rst_n, push && out_valid_reg && !out_ready, skid_valid_reg)

endmodule

`default_nettype wire

### rtl/tlv_crc32_frame_parser_core.sv
// ----------------------------------------------------------------------------
// tlv_crc32_frame_parser_core
// Streaming type-length-value deframer with CRC-32 check.
// ----------------------------------------------------------------------------
// The ingress channel carries one raw byte per request. A frame is a type
// byte, a 4-byte big-endian length, the payload, then a 4-byte big-endian
// reflected CRC-32 of the payload. Every payload byte leaves on the egress
// channel at once as kind 0, tagged with the frame's type and length. After
// the fourth CRC byte, one verdict request leaves with kind 1 (good) or
// kind 2 (mismatch); the next byte then starts a new frame. Header and
// early CRC bytes produce nothing on the egress side.
// Each result is registered in the output register, or in the skid entry
// while the receiver stalls. Throughput is one byte per cycle while ingress
// is ready, set by the single parser register stage whose CRC update is one
// byte of XOR logic. Reset clears the parser to wait for a type byte and
// empties the output. When the receiver stalls, a skid entry behind the
// output register takes one more result, so ingress stays ready until both
// entries are full and then drops ready until the receiver drains a result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_crc32_frame_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    tlvcrc_in_if.sink    ingress,
    tlvcrc_out_if.source egress
);
    import tlvcrc_pkg::*;

    logic    res_valid;
    result_t res;
    logic    space;
    result_t out_data;

    // Byte accepted only while the output side can take its possible result.
    assign ingress.ready = space;

    tlvcrc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ingress.valid),
        .in_byte   (ingress.in_byte),
        .in_ready  (space),
        .res_valid (res_valid),
        .res       (res)
    );

    tlvcrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (egress.valid),
        .out_ready (egress.ready),
        .out_data  (out_data)
    );

    assign egress.out_kind     = out_data.kind;
    assign egress.out_byte     = out_data.data;
    assign egress.frame_type   = out_data.frame_type;
    assign egress.frame_length = out_data.frame_length;

endmodule

`default_nettype wire
